/* hdl/mbrtu_pkg.sv */
package mbrtu_pkg;

  localparam logic [1:0] CMD_RX     = 2'd0;
  localparam logic [1:0] CMD_WRITE  = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;
  localparam logic [1:0] CMD_COUNTS = 2'd3;

  localparam logic [1:0] CFG_DEV   = 2'd0;
  localparam logic [1:0] CFG_BASE  = 2'd1;
  localparam logic [1:0] CFG_COUNT = 2'd2;

  localparam logic [7:0] UNIT_MAX    = 8'd247;
  localparam logic [7:0] FUNC_READ   = 8'h03;
  localparam logic [7:0] EXC_FLAG    = 8'h80;
  localparam logic [7:0] EXC_ADDRESS = 8'h02;
  localparam logic [7:0] EXC_DATA    = 8'h03;

  typedef enum logic [7:0] {
    PS_UNIT    = 8'b0000_0001,
    PS_FUNC    = 8'b0000_0010,
    PS_ADDR_HI = 8'b0000_0100,
    PS_ADDR_LO = 8'b0000_1000,
    PS_QTY_HI  = 8'b0001_0000,
    PS_QTY_LO  = 8'b0010_0000,
    PS_CRC_LO  = 8'b0100_0000,
    PS_CRC_HI  = 8'b1000_0000
  } parse_state_t;

  // job kinds handed from front to back
  localparam logic [2:0] JOB_DATA   = 3'd0;
  localparam logic [2:0] JOB_EXC    = 3'd1;
  localparam logic [2:0] JOB_LWRITE = 3'd2;
  localparam logic [2:0] JOB_LREAD  = 3'd3;
  localparam logic [2:0] JOB_LVAL   = 3'd4;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  exc;
    logic [15:0] offset;
    logic [15:0] qty;
    logic [15:0] value;
    logic        ok;
  } job_t;

  function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) c = (c >> 1) ^ 16'hA001;
      else      c = c >> 1;
    end
    return c;
  endfunction

endpackage

/* hdl/mbrtu_front.sv */
module mbrtu_front #(
  parameter int NUM_REGS     = 256,
  parameter int MAX_QUANTITY = 124
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         command,
  input  logic [7:0]         rx_byte,
  input  logic [15:0]        reg_address,
  input  logic [15:0]        reg_value,
  input  logic [7:0]         dev_addr,
  input  logic [15:0]        base_addr,
  input  logic [8:0]         reg_count,
  output logic               job_valid,
  input  logic               job_ready,
  output mbrtu_pkg::job_t    job
);

  localparam int CW = $clog2(NUM_REGS + 1);

  mbrtu_pkg::parse_state_t ps_r, ps_nxt;
  logic [7:0]  unit_r, unit_nxt;
  logic [15:0] start_r, start_nxt, qty_r, qty_nxt, crc_r, crc_nxt;
  logic [7:0]  crc1_r, crc1_nxt;
  logic [15:0] err_r, err_nxt, idat_r, idat_nxt, iadr_r, iadr_nxt;

  logic [CW-1:0] eff_cnt;
  logic [16:0]   diff, loc_diff, end_sum;
  logic          emit;
  mbrtu_pkg::job_t jb;

  always_comb begin
    if (int'(reg_count) > NUM_REGS) eff_cnt = CW'(NUM_REGS);
    else eff_cnt = CW'(reg_count);
  end

  assign diff     = {1'b0, start_r} - {1'b0, base_addr};
  assign loc_diff = {1'b0, reg_address} - {1'b0, base_addr};
  assign end_sum  = diff + {1'b0, qty_r};

  assign in_ready = job_ready;

  always_comb begin
    ps_nxt = ps_r; unit_nxt = unit_r; start_nxt = start_r; qty_nxt = qty_r;
    crc_nxt = crc_r; crc1_nxt = crc1_r;
    err_nxt = err_r; idat_nxt = idat_r; iadr_nxt = iadr_r;
    emit = 1'b0;
    jb = '0;
    if (in_valid && in_ready) begin
      unique case (command)
        mbrtu_pkg::CMD_RX: begin
          unique case (ps_r)
            mbrtu_pkg::PS_UNIT: begin
              if (rx_byte >= 8'd1 && rx_byte <= mbrtu_pkg::UNIT_MAX) begin
                unit_nxt = rx_byte;
                crc_nxt = mbrtu_pkg::crc_add(16'hFFFF, rx_byte);
                ps_nxt = mbrtu_pkg::PS_FUNC;
              end else begin
                err_nxt = err_r + 16'd1; crc_nxt = 16'hFFFF;
              end
            end
            mbrtu_pkg::PS_FUNC: begin
              if (rx_byte == mbrtu_pkg::FUNC_READ) begin
                crc_nxt = mbrtu_pkg::crc_add(crc_r, rx_byte);
                ps_nxt = mbrtu_pkg::PS_ADDR_HI;
              end else begin
                err_nxt = err_r + 16'd1; crc_nxt = 16'hFFFF; ps_nxt = mbrtu_pkg::PS_UNIT;
              end
            end
            mbrtu_pkg::PS_ADDR_HI: begin
              crc_nxt = mbrtu_pkg::crc_add(crc_r, rx_byte);
              start_nxt = {rx_byte, 8'h00}; ps_nxt = mbrtu_pkg::PS_ADDR_LO;
            end
            mbrtu_pkg::PS_ADDR_LO: begin
              crc_nxt = mbrtu_pkg::crc_add(crc_r, rx_byte);
              start_nxt = {start_r[15:8], rx_byte}; ps_nxt = mbrtu_pkg::PS_QTY_HI;
            end
            mbrtu_pkg::PS_QTY_HI: begin
              crc_nxt = mbrtu_pkg::crc_add(crc_r, rx_byte);
              qty_nxt = {rx_byte, 8'h00}; ps_nxt = mbrtu_pkg::PS_QTY_LO;
            end
            mbrtu_pkg::PS_QTY_LO: begin
              crc_nxt = mbrtu_pkg::crc_add(crc_r, rx_byte);
              qty_nxt = {qty_r[15:8], rx_byte}; ps_nxt = mbrtu_pkg::PS_CRC_LO;
            end
            mbrtu_pkg::PS_CRC_LO: begin
              crc1_nxt = rx_byte; ps_nxt = mbrtu_pkg::PS_CRC_HI;
            end
            mbrtu_pkg::PS_CRC_HI: begin
              ps_nxt = mbrtu_pkg::PS_UNIT; crc_nxt = 16'hFFFF;
              if ({rx_byte, crc1_r} != crc_r) begin
                err_nxt = err_r + 16'd1;
              end else if (unit_r == dev_addr) begin
                emit = 1'b1;
                jb.qty = qty_r;
                jb.offset = diff[15:0];
                if (qty_r == 16'd0 || qty_r > 16'(MAX_QUANTITY)) begin
                  jb.kind = mbrtu_pkg::JOB_EXC; jb.exc = mbrtu_pkg::EXC_DATA;
                  idat_nxt = idat_r + 16'd1;
                end else if (diff[16] || end_sum > 17'(eff_cnt)) begin
                  jb.kind = mbrtu_pkg::JOB_EXC; jb.exc = mbrtu_pkg::EXC_ADDRESS;
                  iadr_nxt = iadr_r + 16'd1;
                end else begin
                  jb.kind = mbrtu_pkg::JOB_DATA;
                end
              end
            end
            default: begin
              err_nxt = err_r + 16'd1; crc_nxt = 16'hFFFF; ps_nxt = mbrtu_pkg::PS_UNIT;
            end
          endcase
        end
        mbrtu_pkg::CMD_WRITE, mbrtu_pkg::CMD_READ: begin
          emit = 1'b1;
          jb.kind = (command == mbrtu_pkg::CMD_WRITE) ? mbrtu_pkg::JOB_LWRITE
                                                     : mbrtu_pkg::JOB_LREAD;
          jb.offset = loc_diff[15:0];
          jb.value = reg_value;
          jb.ok = !loc_diff[16] && (loc_diff < 17'(eff_cnt));
        end
        default: begin
          emit = 1'b1;
          jb.kind = mbrtu_pkg::JOB_LVAL;
          jb.ok = 1'b1;
          if (reg_address == 16'd0) jb.value = err_r;
          else if (reg_address == 16'd1) jb.value = idat_r;
          else if (reg_address == 16'd2) jb.value = iadr_r;
          else jb.ok = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ps_r <= mbrtu_pkg::PS_UNIT; unit_r <= '0; start_r <= '0; qty_r <= '0;
      crc_r <= 16'hFFFF; crc1_r <= '0; err_r <= '0; idat_r <= '0; iadr_r <= '0;
      job_valid <= 1'b0;
    end else begin
      ps_r <= ps_nxt; unit_r <= unit_nxt; start_r <= start_nxt; qty_r <= qty_nxt;
      crc_r <= crc_nxt; crc1_r <= crc1_nxt; err_r <= err_nxt; idat_r <= idat_nxt;
      iadr_r <= iadr_nxt;
      job_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) job <= jb;
  end

  a_ps_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(ps_r))
    else $error("parser state not one-hot");
  a_job_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    job_valid |=> !job_valid)
    else $error("job held two cycles");
  a_no_take: assert property (@(posedge clk) disable iff (!rst_n)
    job_valid |-> !in_ready)
    else $error("beat taken while job pending");

endmodule

/* hdl/mbrtu_back.sv */
module mbrtu_back #(
  parameter int NUM_REGS = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             job_valid,
  output logic             job_ready,
  input  mbrtu_pkg::job_t  job,
  input  logic [7:0]       dev_addr,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [55:0]      out_tdata,
  output logic             out_tlast,
  output logic             out_tuser
);

  localparam int AW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_HEAD = 4'b0010,
    B_BODY = 4'b0100,
    B_OUT  = 4'b1000
  } back_state_t;

  logic [15:0] mem [NUM_REGS];
  logic [15:0] rd_q;

  back_state_t st_r, st_nxt;
  mbrtu_pkg::job_t jb_r;
  // byte stream builder: pending bytes held in a small shift buffer
  logic [7:0]  len_r, len_nxt;   // total bytes before crc
  logic [7:0]  pos_r, pos_nxt;   // bytes produced so far
  logic [15:0] crc_r, crc_nxt;
  logic [AW-1:0] rd_addr_r, rd_addr_nxt;
  logic        rd_pend_r, rd_pend_nxt;
  logic [7:0]  lo_r, lo_nxt;
  logic        lo_have_r, lo_have_nxt;
  logic [31:0] chunk_r, chunk_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic        done_r, done_nxt;
  logic [55:0] od_r, od_nxt;
  logic        ol_r, ol_nxt, ou_r, ou_nxt, ov_r, ov_nxt;
  logic [7:0]  bsel;
  logic        bval;
  logic [7:0]  hdr [3];
  logic        wr_en;
  logic        out_free;
  logic        clr_r;
  logic [AW-1:0] clr_addr_r;

  assign out_free  = !ov_r || out_tready;
  assign job_ready = (st_r == B_IDLE) && out_free && !job_valid && !clr_r;
  assign wr_en = job_valid && job.kind == mbrtu_pkg::JOB_LWRITE && job.ok;

  always_ff @(posedge clk) begin
    if (clr_r) mem[clr_addr_r] <= '0;
    else if (wr_en) mem[job.offset[AW-1:0]] <= job.value;
    rd_q <= mem[(job_valid && job.kind == mbrtu_pkg::JOB_LREAD) ?
                job.offset[AW-1:0] : rd_addr_r];
  end

  always_comb begin
    hdr[0] = dev_addr;
    hdr[1] = (jb_r.kind == mbrtu_pkg::JOB_EXC) ? (mbrtu_pkg::FUNC_READ | mbrtu_pkg::EXC_FLAG)
                                               : mbrtu_pkg::FUNC_READ;
    hdr[2] = (jb_r.kind == mbrtu_pkg::JOB_EXC) ? jb_r.exc : {jb_r.qty[6:0], 1'b0};
  end

  always_comb begin
    st_nxt = st_r; len_nxt = len_r; pos_nxt = pos_r; crc_nxt = crc_r;
    rd_addr_nxt = rd_addr_r; rd_pend_nxt = 1'b0; lo_nxt = lo_r; lo_have_nxt = lo_have_r;
    chunk_nxt = chunk_r; cnt_nxt = cnt_r; done_nxt = done_r;
    od_nxt = od_r; ol_nxt = ol_r; ou_nxt = ou_r;
    ov_nxt = ov_r && !out_tready;
    bsel = 8'h00; bval = 1'b0;
    unique case (st_r)
      B_IDLE: begin
        if (job_valid) begin
          if (job.kind == mbrtu_pkg::JOB_DATA || job.kind == mbrtu_pkg::JOB_EXC) begin
            st_nxt = B_HEAD;
            len_nxt = (job.kind == mbrtu_pkg::JOB_EXC) ? 8'd3 : 8'(3 + 2 * job.qty[6:0]);
            pos_nxt = 8'd0; crc_nxt = 16'hFFFF; chunk_nxt = '0; cnt_nxt = '0;
            done_nxt = 1'b0; lo_have_nxt = 1'b0;
            rd_addr_nxt = AW'(job.offset);
          end else if (job.kind == mbrtu_pkg::JOB_LREAD) begin
            st_nxt = B_OUT;
          end else begin
            ov_nxt = 1'b1; ou_nxt = 1'b0; ol_nxt = 1'b0;
            od_nxt = {4'd0, job.ok, (job.kind == mbrtu_pkg::JOB_LVAL) ? job.value : 16'd0,
                      3'd0, 32'd0};
          end
        end
      end
      B_OUT: begin
        st_nxt = B_IDLE;
        ov_nxt = 1'b1; ou_nxt = 1'b0; ol_nxt = 1'b0;
        od_nxt = {4'd0, jb_r.ok, jb_r.ok ? rd_q : 16'd0, 3'd0, 32'd0};
      end
      default: begin
        // one byte per cycle into a non-full chunk; chunk out when full or done
        if (cnt_r == 3'd4 || done_r) begin
          if (out_free) begin
            ov_nxt = 1'b1; ou_nxt = 1'b1;
            ol_nxt = done_r;
            od_nxt = {21'd0, cnt_r, chunk_r};
            chunk_nxt = '0; cnt_nxt = '0;
            if (done_r) st_nxt = B_IDLE;
          end
        end else begin
          if (pos_r < 8'd3) begin
            bsel = hdr[pos_r[1:0]]; bval = 1'b1;
            if (pos_r == 8'd2 && jb_r.kind == mbrtu_pkg::JOB_DATA) rd_pend_nxt = 1'b1;
          end else if (pos_r < len_r) begin
            if (lo_have_r) begin
              bsel = lo_r; bval = 1'b1; lo_have_nxt = 1'b0;
              if (pos_r + 8'd1 < len_r) rd_pend_nxt = 1'b1;
            end else if (rd_pend_r) begin
              bsel = rd_q[15:8]; bval = 1'b1; lo_nxt = rd_q[7:0]; lo_have_nxt = 1'b1;
              rd_addr_nxt = (rd_addr_r == AW'(NUM_REGS - 1)) ? '0 : rd_addr_r + AW'(1);
            end
          end else if (pos_r == len_r) begin
            bsel = crc_r[7:0]; bval = 1'b1;
          end else begin
            bsel = crc_r[15:8]; bval = 1'b1; done_nxt = 1'b1;
          end
          if (bval) begin
            if (pos_r < len_r) crc_nxt = mbrtu_pkg::crc_add(crc_r, bsel);
            pos_nxt = pos_r + 8'd1;
            chunk_nxt = chunk_r | (32'(bsel) << {cnt_r[1:0], 3'b000});
            cnt_nxt = cnt_r + 3'd1;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= B_IDLE; ov_r <= 1'b0; rd_pend_r <= 1'b0; lo_have_r <= 1'b0; done_r <= 1'b0;
      cnt_r <= '0;
      clr_r <= 1'b1; clr_addr_r <= '0;
    end else begin
      st_r <= st_nxt; ov_r <= ov_nxt; rd_pend_r <= rd_pend_nxt; lo_have_r <= lo_have_nxt;
      done_r <= done_nxt; cnt_r <= cnt_nxt;
      if (clr_r) begin
        clr_addr_r <= clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(NUM_REGS - 1)) clr_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_valid) jb_r <= job;
    len_r <= len_nxt; pos_r <= pos_nxt; crc_r <= crc_nxt; rd_addr_r <= rd_addr_nxt;
    lo_r <= lo_nxt; chunk_r <= chunk_nxt; od_r <= od_nxt; ol_r <= ol_nxt; ou_r <= ou_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tlast  = ol_r;
  assign out_tuser  = ou_r;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled beat changed");
  a_chunk_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[34:32] != 3'd0 && out_tdata[34:32] <= 3'd4)
    else $error("bad chunk count");
  a_job_idle: assert property (@(posedge clk) disable iff (!rst_n)
    job_valid |-> st_r == B_IDLE)
    else $error("job while busy");

endmodule

/* hdl/modbus_rtu_read_register_slave_unit.sv */
// A local write is answered through the front job register and the output
// register; a local read also passes the B_OUT state after the store read.
// One answer byte per cycle, but none in cycles that send a chunk or wait on
// out_tready; input is held while the back end is busy.
// Reset: rst_n synchronous; clears parser, counters and output valid, sets
// config to defaults, then a pass zeroes the store with in_tready low.
module modbus_rtu_read_register_slave_unit #(
  parameter int NUM_REGS     = 256,
  parameter int MAX_QUANTITY = 124
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [2:0]  in_tuser,   // command[1:0]; bit 2 zero
  input  logic [39:0] in_tdata,   // rx_byte, reg_address, reg_value
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // tx_byte0..3, tx_count, read_value, access_ok
  output logic        out_tlast,  // tx_last
  output logic        out_tuser,  // kind
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [7:0]  dev_r;
  logic [15:0] base_r;
  logic [8:0]  count_r;
  logic        job_valid, job_ready;
  mbrtu_pkg::job_t job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_r <= 8'd1; base_r <= 16'h4000; count_r <= 9'd256;
    end else if (cfg_we) begin
      if (cfg_index == mbrtu_pkg::CFG_DEV) dev_r <= cfg_data[7:0];
      else if (cfg_index == mbrtu_pkg::CFG_BASE) base_r <= cfg_data;
      else if (cfg_index == mbrtu_pkg::CFG_COUNT) count_r <= cfg_data[8:0];
    end
  end

  mbrtu_front #(.NUM_REGS(NUM_REGS), .MAX_QUANTITY(MAX_QUANTITY)) u_front (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready),
    .command(in_tuser[1:0]), .rx_byte(in_tdata[7:0]), .reg_address(in_tdata[23:8]),
    .reg_value(in_tdata[39:24]), .dev_addr(dev_r), .base_addr(base_r),
    .reg_count(count_r), .job_valid, .job_ready, .job);

  mbrtu_back #(.NUM_REGS(NUM_REGS)) u_back (
    .clk, .rst_n, .job_valid, .job_ready, .job, .dev_addr(dev_r),
    .out_tvalid, .out_tready, .out_tdata, .out_tlast, .out_tuser);

endmodule
